>>> rtl/core/ctat_pkg.sv
// ----------------------------------------------------------------------------
// ctat_pkg
// Shared types, constants and sector geometry decode for the cue track
// address translator.
// ----------------------------------------------------------------------------
package ctat_pkg;

  localparam int MAX_TRACKS     = 128;
  localparam int LOGICAL_SECTOR = 2048;

  localparam int IDX_W     = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
  localparam int CNT_W     = IDX_W + 1;
  localparam int SLOT_W    = 7;
  localparam int LBA_W     = 20;
  localparam int MODE_W    = 3;
  localparam int LBYTE_W   = 31;
  localparam int REQ_W     = 32;
  localparam int PHYS_W    = 32;
  localparam int CHUNK_W   = 12;
  localparam int SEC_OFF_W = $clog2(LOGICAL_SECTOR);
  localparam int SIZE_W    = 12;
  localparam int DOFF_W    = 5;

  // Depth of the queue between front and back; a power of two.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic {
    JOB_LOAD  = 1'b0,
    JOB_XLATE = 1'b1
  } job_kind_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SCAN,
    BK_MUL,
    BK_FIN
  } back_state_e;

  typedef struct packed {
    job_kind_e              kind;
    logic [IDX_W-1:0]       slot;
    logic [LBA_W-1:0]       start_lba;
    logic [LBA_W-1:0]       end_lba;
    logic [MODE_W-1:0]      mode;
    logic [LBA_W-1:0]       lba;
    logic [SEC_OFF_W-1:0]   in_sector;
    logic [CHUNK_W-1:0]     chunk;
  } job_t;

  typedef struct packed {
    logic [LBA_W-1:0]  start_lba;
    logic [LBA_W-1:0]  end_lba;
    logic [MODE_W-1:0] mode;
  } entry_t;

  localparam logic [MODE_W-1:0] MODE_AUDIO     = 3'd0;
  localparam logic [MODE_W-1:0] MODE_M1_2048   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_M1_2352   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_M2_2336   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_M2_2352   = 3'd4;

  // Raw sector size per geometry code; unknown codes behave as MODE1/2352.
  function automatic logic [SIZE_W-1:0] geo_size(input logic [MODE_W-1:0] mode);
    logic [SIZE_W-1:0] sz;
    unique case (mode)
      MODE_AUDIO:   sz = 12'd2352;
      MODE_M1_2048: sz = 12'd2048;
      MODE_M1_2352: sz = 12'd2352;
      MODE_M2_2336: sz = 12'd2336;
      MODE_M2_2352: sz = 12'd2352;
      default:      sz = 12'd2352;
    endcase
    return sz;
  endfunction

  // User data offset inside the raw sector.
  function automatic logic [DOFF_W-1:0] geo_offset(input logic [MODE_W-1:0] mode);
    logic [DOFF_W-1:0] off;
    unique case (mode)
      MODE_AUDIO:   off = 5'd0;
      MODE_M1_2048: off = 5'd0;
      MODE_M1_2352: off = 5'd16;
      MODE_M2_2336: off = 5'd8;
      MODE_M2_2352: off = 5'd24;
      default:      off = 5'd16;
    endcase
    return off;
  endfunction

endpackage

>>> rtl/core/ctat_ram.sv
// ----------------------------------------------------------------------------
// ctat_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module ctat_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                       clk_i,
  input  logic                                       we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                           wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                           rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/ctat_front.sv
// ----------------------------------------------------------------------------
// ctat_front
// Accepts input words, splits the logical byte position into sector and
// offset, works out the chunk length and queues the job for the back end.
// ----------------------------------------------------------------------------
module ctat_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        action_i,
  input  logic [ctat_pkg::SLOT_W-1:0]  track_slot_i,
  input  logic [ctat_pkg::LBA_W-1:0]   start_lba_i,
  input  logic [ctat_pkg::LBA_W-1:0]   end_lba_i,
  input  logic [ctat_pkg::MODE_W-1:0]  track_mode_i,
  input  logic [ctat_pkg::LBYTE_W-1:0] logical_byte_i,
  input  logic [ctat_pkg::REQ_W-1:0]   request_bytes_i,
  output logic                        job_vld_o,
  output ctat_pkg::job_t              job_o,
  input  logic                        job_pop_i
);
  import ctat_pkg::*;

  job_t              queue_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;

  logic              full;
  logic              accept;
  logic              push;
  logic              pop;
  job_t              job_new;
  logic [CHUNK_W-1:0] rest;

  assign full       = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;
  assign job_vld_o  = (count_q != '0);
  assign pop        = job_pop_i && job_vld_o;

  always_comb begin
    job_new           = '0;
    job_new.kind      = action_i ? JOB_XLATE : JOB_LOAD;
    job_new.slot      = IDX_W'(track_slot_i);
    job_new.start_lba = start_lba_i;
    job_new.end_lba   = end_lba_i;
    job_new.mode      = track_mode_i;
    job_new.lba       = logical_byte_i[SEC_OFF_W +: LBA_W];
    job_new.in_sector = logical_byte_i[SEC_OFF_W-1:0];
    rest              = CHUNK_W'(LOGICAL_SECTOR) - CHUNK_W'(job_new.in_sector);
    if (request_bytes_i < REQ_W'(rest)) begin
      job_new.chunk = request_bytes_i[CHUNK_W-1:0];
    end else begin
      job_new.chunk = rest;
    end
  end

  // A load aimed past the end of the table is taken and dropped here.
  assign push = accept &&
                ((action_i == 1'b1) || (int'(track_slot_i) < MAX_TRACKS));

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop  ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= job_new;
    end
  end

  assign job_o = queue_q[rd_ptr_q];

endmodule

>>> rtl/core/ctat_back.sv
// ----------------------------------------------------------------------------
// ctat_back
// Carries out queued jobs: loads write the track table, translates scan it
// one entry per cycle for the first match and build the result word.
// ----------------------------------------------------------------------------
module ctat_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         job_vld_i,
  input  ctat_pkg::job_t               job_i,
  output logic                         job_pop_o,
  input  logic                         single_file_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         hit_o,
  output logic [ctat_pkg::SLOT_W-1:0]  track_index_o,
  output logic [ctat_pkg::PHYS_W-1:0]  physical_offset_o,
  output logic [ctat_pkg::CHUNK_W-1:0] chunk_bytes_o
);
  import ctat_pkg::*;

  back_state_e state_q, state_d;

  logic [MAX_TRACKS-1:0] valid_q;
  logic [LBA_W-1:0]      lba_q;
  logic [SEC_OFF_W-1:0]  in_sector_q;
  logic [CHUNK_W-1:0]    chunk_q;
  logic [CNT_W-1:0]      ptr_q, ptr_d;
  logic                  rd_pend_q, rd_pend_d;
  logic [IDX_W-1:0]      rd_idx_q;
  logic [IDX_W-1:0]      hit_idx_q;
  logic                  hit_q;
  logic [LBA_W-1:0]      factor_q;
  logic [SIZE_W-1:0]     size_q;
  logic [DOFF_W-1:0]     doff_q;
  logic [PHYS_W-1:0]     prod_q;

  logic                  out_vld_q;
  logic                  out_hit_q;
  logic [SLOT_W-1:0]     out_idx_q;
  logic [PHYS_W-1:0]     out_phys_q;
  logic [CHUNK_W-1:0]    out_chunk_q;

  entry_t                ram_wdata;
  entry_t                ram_rdata;
  logic                  ram_we;
  logic [IDX_W-1:0]      ram_raddr;

  logic                  issue;
  logic                  match;
  logic                  scan_done;
  logic                  out_free;
  logic                  take_load;
  logic                  take_xlate;
  logic                  do_fin;

  assign ram_wdata = '{start_lba: job_i.start_lba, end_lba: job_i.end_lba, mode: job_i.mode};

  ctat_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (MAX_TRACKS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (job_i.slot),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign issue     = (ptr_q != CNT_W'(MAX_TRACKS));
  assign ram_raddr = ptr_q[IDX_W-1:0];
  assign match     = rd_pend_q && valid_q[rd_idx_q] &&
                     (lba_q >= ram_rdata.start_lba) && (lba_q < ram_rdata.end_lba);
  assign scan_done = !issue && !rd_pend_q;
  assign out_free  = !out_vld_q || !out_stall_i;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE: begin
        if (job_vld_i && (job_i.kind == JOB_XLATE)) begin
          state_d = BK_SCAN;
        end
      end
      BK_SCAN: begin
        if (match) begin
          state_d = BK_MUL;
        end else if (scan_done) begin
          state_d = BK_FIN;
        end
      end
      BK_MUL: begin
        state_d = BK_FIN;
      end
      BK_FIN: begin
        if (out_free) begin
          state_d = BK_IDLE;
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    take_load  = 1'b0;
    take_xlate = 1'b0;
    do_fin     = 1'b0;
    ptr_d      = ptr_q;
    rd_pend_d  = 1'b0;
    unique case (state_q)
      BK_IDLE: begin
        take_load  = job_vld_i && (job_i.kind == JOB_LOAD);
        take_xlate = job_vld_i && (job_i.kind == JOB_XLATE);
        ptr_d      = '0;
      end
      BK_SCAN: begin
        rd_pend_d = issue;
        if (issue) begin
          ptr_d = ptr_q + 1'b1;
        end
      end
      BK_MUL: begin
      end
      BK_FIN: begin
        do_fin = out_free;
      end
      default: begin
      end
    endcase
  end

  assign job_pop_o = take_load || take_xlate;
  assign ram_we    = take_load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= BK_IDLE;
      valid_q   <= '0;
      rd_pend_q <= 1'b0;
      ptr_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      rd_pend_q <= rd_pend_d;
      ptr_q     <= ptr_d;
      if (take_load) begin
        valid_q[job_i.slot] <= 1'b1;
      end
      if (do_fin) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q <= ptr_q[IDX_W-1:0];
    if (take_xlate) begin
      lba_q       <= job_i.lba;
      in_sector_q <= job_i.in_sector;
      chunk_q     <= job_i.chunk;
      hit_q       <= 1'b0;
    end
    // In a single image file the base and the in-track part fold into lba * size.
    if ((state_q == BK_SCAN) && match) begin
      hit_q     <= 1'b1;
      hit_idx_q <= rd_idx_q;
      factor_q  <= single_file_i ? lba_q : lba_q - ram_rdata.start_lba;
      size_q    <= geo_size(ram_rdata.mode);
      doff_q    <= geo_offset(ram_rdata.mode);
    end
    if (state_q == BK_MUL) begin
      prod_q <= PHYS_W'(factor_q) * PHYS_W'(size_q);
    end
    if (do_fin) begin
      out_hit_q <= hit_q;
      if (hit_q) begin
        out_idx_q   <= SLOT_W'(hit_idx_q);
        out_phys_q  <= prod_q + PHYS_W'(doff_q) + PHYS_W'(in_sector_q);
        out_chunk_q <= chunk_q;
      end else begin
        out_idx_q   <= '0;
        out_phys_q  <= '0;
        out_chunk_q <= '0;
      end
    end
  end

  assign out_valid_o       = out_vld_q;
  assign hit_o             = out_hit_q;
  assign track_index_o     = out_idx_q;
  assign physical_offset_o = out_phys_q;
  assign chunk_bytes_o     = out_chunk_q;

endmodule

>>> rtl/core/cue_track_address_translator.sv
// ----------------------------------------------------------------------------
// cue_track_address_translator
// Track table and logical-to-raw byte offset translation for CD images.
// ----------------------------------------------------------------------------
// Input words arrive on a valid/stall channel. A load word (action 0) writes
// one track entry and gives no result; a translate word (action 1) gives one
// result word on the output valid/stall channel: hit, track index, physical
// byte offset and chunk length. A two-word queue sits between the input side
// and the execution side, so new words are taken while a result waits.
// A translate scans the track table RAM one entry per cycle until the first
// match, or through all MAX_TRACKS entries on a miss; the single read port
// of the table sets this pace.
// At reset all table entries become invalid, the queue and the output
// register empty, and single_file returns to 1. cfg_we_i writes single_file.
// While the receiver stalls, the result is held in the output register, the
// execution side waits with its next result, and once the queue is full the
// input channel stalls.
// ----------------------------------------------------------------------------
module cue_track_address_translator (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic                          cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          action_i,
  input  logic [ctat_pkg::SLOT_W-1:0]   track_slot_i,
  input  logic [ctat_pkg::LBA_W-1:0]    start_lba_i,
  input  logic [ctat_pkg::LBA_W-1:0]    end_lba_i,
  input  logic [ctat_pkg::MODE_W-1:0]   track_mode_i,
  input  logic [ctat_pkg::LBYTE_W-1:0]  logical_byte_i,
  input  logic [ctat_pkg::REQ_W-1:0]    request_bytes_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          hit_o,
  output logic [ctat_pkg::SLOT_W-1:0]   track_index_o,
  output logic [ctat_pkg::PHYS_W-1:0]   physical_offset_o,
  output logic [ctat_pkg::CHUNK_W-1:0]  chunk_bytes_o
);
  import ctat_pkg::*;

  logic single_file_q;
  logic job_vld;
  job_t job;
  logic job_pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      single_file_q <= 1'b1;
    end else if (cfg_we_i) begin
      single_file_q <= cfg_wdata_i;
    end
  end

  ctat_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .action_i        (action_i),
    .track_slot_i    (track_slot_i),
    .start_lba_i     (start_lba_i),
    .end_lba_i       (end_lba_i),
    .track_mode_i    (track_mode_i),
    .logical_byte_i  (logical_byte_i),
    .request_bytes_i (request_bytes_i),
    .job_vld_o       (job_vld),
    .job_o           (job),
    .job_pop_i       (job_pop)
  );

  ctat_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .job_vld_i         (job_vld),
    .job_i             (job),
    .job_pop_o         (job_pop),
    .single_file_i     (single_file_q),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .hit_o             (hit_o),
    .track_index_o     (track_index_o),
    .physical_offset_o (physical_offset_o),
    .chunk_bytes_o     (chunk_bytes_o)
  );

endmodule

>>> dv/cue_track_address_translator_tb.sv
// ----------------------------------------------------------------------------
// cue_track_address_translator_tb
// Self-checking testbench for the cue track address translator. Track table
// loads and translate words are sent on the input channel with random gaps.
// A predictor in the testbench keeps its own track table and single_file
// setting, works out each translate result when its word is accepted, and a
// checker compares every result word field by field in order. Directed tests
// cover each geometry code, the ends of the LBA space, empty and inverted
// ranges, a zero request and both file layouts. A long receiver hold-off
// fills the block, and then random disc layouts run with random content.
// ----------------------------------------------------------------------------
module cue_track_address_translator_tb;

  timeunit 1ns;
  timeprecision 1ps;

  import ctat_pkg::*;

  localparam int DRAIN_CYCLES  = MAX_TRACKS + 8;
  localparam int RANDOM_WORDS  = 1600;
  localparam logic [LBA_W-1:0] LBA_TOP = '1;

  typedef struct packed {
    job_kind_e            action;
    logic [SLOT_W-1:0]    slot;
    logic [LBA_W-1:0]     start_lba;
    logic [LBA_W-1:0]     end_lba;
    logic [MODE_W-1:0]    mode;
    logic [LBYTE_W-1:0]   lbyte;
    logic [REQ_W-1:0]     req;
  } track_word_t;

  typedef struct packed {
    logic                 hit;
    logic [SLOT_W-1:0]    index;
    logic [PHYS_W-1:0]    offset;
    logic [CHUNK_W-1:0]   chunk;
  } xlate_res_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic                  cfg_wdata_i = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  logic                  action_i = 1'b0;
  logic [SLOT_W-1:0]     track_slot_i = '0;
  logic [LBA_W-1:0]      start_lba_i = '0;
  logic [LBA_W-1:0]      end_lba_i = '0;
  logic [MODE_W-1:0]     track_mode_i = '0;
  logic [LBYTE_W-1:0]    logical_byte_i = '0;
  logic [REQ_W-1:0]      request_bytes_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic                  hit_o;
  logic [SLOT_W-1:0]     track_index_o;
  logic [PHYS_W-1:0]     physical_offset_o;
  logic [CHUNK_W-1:0]    chunk_bytes_o;

  // Predictor state: a private copy of the track table and the register.
  logic [LBA_W-1:0]      tbl_start [MAX_TRACKS];
  logic [LBA_W-1:0]      tbl_end   [MAX_TRACKS];
  logic [MODE_W-1:0]     tbl_mode  [MAX_TRACKS];
  logic                  tbl_used  [MAX_TRACKS];
  logic                  single_file_cfg = 1'b1;

  xlate_res_t            xlate_q[$];
  xlate_res_t            want;
  int                    err_cnt = 0;
  int                    words_sent = 0;
  logic                  quiet = 1'b0;
  int                    hold_left = 0;
  int                    stall_left = 0;
  logic                  out_taken;

  always #5 clk_i = ~clk_i;

  cue_track_address_translator i_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .action_i          (action_i),
    .track_slot_i      (track_slot_i),
    .start_lba_i       (start_lba_i),
    .end_lba_i         (end_lba_i),
    .track_mode_i      (track_mode_i),
    .logical_byte_i    (logical_byte_i),
    .request_bytes_i   (request_bytes_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .hit_o             (hit_o),
    .track_index_o     (track_index_o),
    .physical_offset_o (physical_offset_o),
    .chunk_bytes_o     (chunk_bytes_o)
  );

  // Scans the table in slot order; the first valid entry holding the LBA wins.
  function automatic xlate_res_t translate_position(logic [LBYTE_W-1:0] lbyte,
                                                    logic [REQ_W-1:0] req);
    xlate_res_t       r;
    logic [LBA_W-1:0] lba;
    logic [63:0]      in_sec;
    logic [63:0]      sz;
    logic [63:0]      doff;
    logic [63:0]      base;
    logic [63:0]      phys;
    logic [63:0]      rest;
    logic             found;
    r      = '0;
    found  = 1'b0;
    lba    = lbyte[LBYTE_W-1:SEC_OFF_W];
    in_sec = 64'(lbyte[SEC_OFF_W-1:0]);
    for (int i = 0; i < MAX_TRACKS; i++) begin
      if (!found && tbl_used[i] && lba >= tbl_start[i] && lba < tbl_end[i]) begin
        found = 1'b1;
        case (tbl_mode[i])
          MODE_AUDIO: begin
            sz = 64'd2352; doff = 64'd0;
          end
          MODE_M1_2048: begin
            sz = 64'd2048; doff = 64'd0;
          end
          MODE_M1_2352: begin
            sz = 64'd2352; doff = 64'd16;
          end
          MODE_M2_2336: begin
            sz = 64'd2336; doff = 64'd8;
          end
          MODE_M2_2352: begin
            sz = 64'd2352; doff = 64'd24;
          end
          // Unknown codes read as MODE1/2352.
          default: begin
            sz = 64'd2352; doff = 64'd16;
          end
        endcase
        base = single_file_cfg ? 64'(tbl_start[i]) * sz : 64'd0;
        phys = base + 64'(lba - tbl_start[i]) * sz + doff + in_sec;
        rest = 64'(LOGICAL_SECTOR) - in_sec;
        if (rest > 64'(req)) begin
          rest = 64'(req);
        end
        r.hit    = 1'b1;
        r.index  = SLOT_W'(i);
        r.offset = phys[PHYS_W-1:0];
        r.chunk  = rest[CHUNK_W-1:0];
      end
    end
    return r;
  endfunction

  // Drives one word after a random gap, none while quiet, and waits for the
  // handshake. Stall is sampled at the falling edge, when every input has settled.
  task automatic send_word(track_word_t w);
    int   gap;
    logic acc;
    gap = quiet ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    action_i        <= w.action;
    track_slot_i    <= w.slot;
    start_lba_i     <= w.start_lba;
    end_lba_i       <= w.end_lba;
    track_mode_i    <= w.mode;
    logical_byte_i  <= w.lbyte;
    request_bytes_i <= w.req;
    do begin
      @(negedge clk_i);
      acc = !in_stall_o;
      @(posedge clk_i);
    end while (!acc);
    words_sent++;
    if (w.action == JOB_LOAD) begin
      tbl_start[w.slot] = w.start_lba;
      tbl_end[w.slot]   = w.end_lba;
      tbl_mode[w.slot]  = w.mode;
      tbl_used[w.slot]  = 1'b1;
    end else begin
      xlate_q = {xlate_q, translate_position(w.lbyte, w.req)};
    end
  endtask

  // Unused fields carry random values so that every input bit moves.
  task automatic load_track(logic [SLOT_W-1:0] slot, logic [LBA_W-1:0] lo,
                            logic [LBA_W-1:0] hi, logic [MODE_W-1:0] mode);
    track_word_t w;
    w.action    = JOB_LOAD;
    w.slot      = slot;
    w.start_lba = lo;
    w.end_lba   = hi;
    w.mode      = mode;
    w.lbyte     = LBYTE_W'($urandom);
    w.req       = $urandom;
    send_word(w);
  endtask

  task automatic translate_at(logic [LBYTE_W-1:0] lbyte, logic [REQ_W-1:0] req);
    track_word_t w;
    w.action    = JOB_XLATE;
    w.slot      = SLOT_W'($urandom);
    w.start_lba = LBA_W'($urandom);
    w.end_lba   = LBA_W'($urandom);
    w.mode      = MODE_W'($urandom);
    w.lbyte     = lbyte;
    w.req       = req;
    send_word(w);
  endtask

  function automatic logic [REQ_W-1:0] rand_request();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return $urandom;
      2, 3:    return $urandom_range(0, 2100);
      default: return $urandom_range(1, 4096);
    endcase
  endfunction

  // Loads give no result, so after the last result the block may still be
  // busy; allow a full table scan before calling it idle.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (xlate_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_single_file(logic v);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    single_file_cfg = v;
  endtask

  // Nothing is loaded yet, so the highest position must miss.
  task automatic test_empty_table();
    translate_at('1, 32'd100);
  endtask

  // One short track per geometry code, unknown codes included.
  task automatic test_geometry();
    logic [LBA_W-1:0]     lo;
    logic [SEC_OFF_W-1:0] off;
    logic [REQ_W-1:0]     req;
    for (int m = 0; m < 8; m++) begin
      lo = LBA_W'(m * 1000 + 100);
      load_track(SLOT_W'(m), lo, lo + 20'd50, MODE_W'(m));
    end
    for (int m = 0; m < 8; m++) begin
      lo  = LBA_W'(m * 1000 + 100 + 3 + m);
      off = (m == 0) ? '0 : (m == 1) ? '1 : SEC_OFF_W'($urandom_range(0, 2047));
      req = (m == 2) ? '0 : (m == 3) ? '1 : REQ_W'($urandom_range(1, 3000));
      translate_at({lo, off}, req);
    end
  endtask

  // Top of the LBA space, and ranges that must never match.
  task automatic test_ranges();
    load_track(7'd127, LBA_TOP - 20'd1, LBA_TOP, MODE_M2_2352);
    translate_at({LBA_TOP - 20'd1, 11'h7FF}, 32'd100);
    translate_at('1, '1);
    load_track(7'd8, 20'd15, 20'd15, MODE_M1_2048);
    load_track(7'd9, 20'd20, 20'd10, MODE_M1_2048);
    translate_at({20'd15, 11'd300}, 32'd5000);
  endtask

  task automatic test_single_file();
    write_single_file(1'b0);
    translate_at({20'd3110, 11'd40}, 32'd2048);
    write_single_file(1'b1);
  endtask

  // The receiver holds off while words keep coming, so the block fills up
  // and stalls its input.
  task automatic test_backpressure();
    quiet = 1'b1;
    @(negedge clk_i);
    hold_left = 300;
    @(posedge clk_i);
    for (int t = 0; t < 12; t++) begin
      translate_at({LBA_W'(100 + t), SEC_OFF_W'(t * 150)}, 32'd4096);
    end
    wait_idle();
    quiet = 1'b0;
  endtask

  // Random disc layouts: a run of near-contiguous tracks is loaded, then mostly
  // translates that land in them, with some stray loads and random positions.
  task automatic test_random_discs();
    int                   stop_at;
    int                   n;
    int                   m;
    int                   k;
    int                   first;
    int                   len;
    int                   cur;
    int                   pick;
    int                   lay_slot [12];
    int                   lay_lo [12];
    int                   lay_hi [12];
    int                   old_slots [$];
    logic [LBA_W-1:0]     lba;
    logic [LBA_W-1:0]     s;
    logic [SEC_OFF_W-1:0] off;
    stop_at = words_sent + RANDOM_WORDS;
    while (words_sent < stop_at) begin
      quiet = ($urandom_range(0, 4) == 0);
      // Retire the previous layout with empty or inverted ranges.
      if ($urandom_range(0, 3) != 0) begin
        foreach (old_slots[j]) begin
          s = LBA_W'($urandom_range(4, LBA_TOP));
          load_track(SLOT_W'(old_slots[j]), s, s - LBA_W'($urandom_range(0, 3)),
                     MODE_W'($urandom_range(0, 7)));
        end
        old_slots.delete();
      end
      if ($urandom_range(0, 2) == 0) begin
        write_single_file(1'($urandom_range(0, 1)));
      end
      n     = $urandom_range(1, 12);
      first = $urandom_range(0, 127);
      case ($urandom_range(0, 3))
        0:       cur = 0;
        1:       cur = $urandom_range(0, 5000);
        2:       cur = $urandom_range(0, LBA_TOP);
        default: cur = LBA_TOP - $urandom_range(0, 1500);
      endcase
      for (k = 0; k < n; k++) begin
        lay_slot[k] = $urandom_range(0, 1) ? (first + k) % 128 : $urandom_range(0, 127);
        len         = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(1, 300);
        lay_lo[k]   = cur;
        lay_hi[k]   = (cur + len > LBA_TOP) ? LBA_TOP : cur + len;
        cur         = lay_hi[k] + ($urandom_range(0, 1) ? 0 : $urandom_range(0, 3));
        if (cur > LBA_TOP) begin
          cur = LBA_TOP;
        end
        load_track(SLOT_W'(lay_slot[k]), LBA_W'(lay_lo[k]), LBA_W'(lay_hi[k]),
                   MODE_W'($urandom_range(0, 7)));
        old_slots = {old_slots, lay_slot[k]};
      end
      m = $urandom_range(10, 45);
      for (int t = 0; t < m; t++) begin
        pick = $urandom_range(0, 19);
        if (pick == 0) begin
          load_track(SLOT_W'($urandom_range(0, 127)), LBA_W'($urandom),
                     LBA_W'($urandom), MODE_W'($urandom_range(0, 7)));
        end else if (pick <= 2) begin
          translate_at(LBYTE_W'($urandom_range(0, 31'h7FFFFFFF)), rand_request());
        end else begin
          k = $urandom_range(0, n - 1);
          case ($urandom_range(0, 7))
            0:       lba = LBA_W'(lay_lo[k]);
            1:       lba = LBA_W'(lay_hi[k] - 1);
            2:       lba = LBA_W'(lay_hi[k]);
            default: lba = (lay_hi[k] > lay_lo[k]) ?
                           LBA_W'($urandom_range(lay_lo[k], lay_hi[k] - 1)) :
                           LBA_W'(lay_lo[k]);
          endcase
          case ($urandom_range(0, 3))
            0:       off = '0;
            1:       off = '1;
            default: off = SEC_OFF_W'($urandom);
          endcase
          translate_at({lba, off}, rand_request());
        end
      end
    end
    quiet = 1'b0;
    wait_idle();
  endtask

  // Result checker and receiver stall. A word is taken at the next rising
  // edge when valid is high and stall is low at the falling edge.
  always begin
    @(negedge clk_i);
    out_taken = (out_valid_o === 1'b1) && !out_stall_i;
    if (out_taken) begin
      if (xlate_q.size() == 0) begin
        $error("result word with no translate pending: hit %0d index %0d offset %0h",
               hit_o, track_index_o, physical_offset_o);
        err_cnt++;
      end else begin
        want = xlate_q.pop_front();
        if (hit_o !== want.hit) begin
          $error("hit: expected %0d, got %0d", want.hit, hit_o);
          err_cnt++;
        end
        if (track_index_o !== want.index) begin
          $error("track_index: expected %0d, got %0d", want.index, track_index_o);
          err_cnt++;
        end
        if (physical_offset_o !== want.offset) begin
          $error("physical_offset: expected %0h, got %0h", want.offset,
                 physical_offset_o);
          err_cnt++;
        end
        if (chunk_bytes_o !== want.chunk) begin
          $error("chunk_bytes: expected %0d, got %0d", want.chunk, chunk_bytes_o);
          err_cnt++;
        end
      end
    end
    @(posedge clk_i);
    if (out_taken) begin
      stall_left = quiet ? 0 : $urandom_range(0, 4);
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  initial begin
    for (int i = 0; i < MAX_TRACKS; i++) begin
      tbl_start[i] = '0;
      tbl_end[i]   = '0;
      tbl_mode[i]  = '0;
      tbl_used[i]  = 1'b0;
    end
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_table();
    test_geometry();
    test_ranges();
    test_single_file();
    test_backpressure();
    test_random_discs();
    if (err_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #15_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
